### rtl/hinv_pkg.sv
package hinv_pkg;

  localparam int COEF_W    = 32;
  localparam int COORD_W   = 10;
  localparam int PROD_W    = COEF_W + COORD_W + 1;
  localparam int ACC_W     = PROD_W + 2;
  localparam int QUOT_W    = 10;
  localparam int BOUND_W   = 11;
  localparam int FRAC_BITS = 30;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;
  localparam int IN_W      = 24;
  localparam int OUT_W     = 24;

  localparam logic [BOUND_W-1:0] MAX_COLS = BOUND_W'(1024);
  localparam logic [BOUND_W-1:0] MAX_ROWS = BOUND_W'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW1_AB     = 3'd0,
    REG_ROW1C_ROW2A = 3'd1,
    REG_ROW2_BC     = 3'd2,
    REG_ROW3_AB     = 3'd3,
    REG_ROW3_C      = 3'd4,
    REG_SRC_WIDTH   = 3'd5,
    REG_SRC_HEIGHT  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] h11, h12, h13;
    logic signed [COEF_W-1:0] h21, h22, h23;
    logic signed [COEF_W-1:0] h31, h32, h33;
  } coef_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] x, y, w;
  } proj_t;

  typedef struct packed {
    logic               okx, oky;
    logic [ACC_W-1:0]   rx, ry;
    logic [ACC_W-1:0]   d;
    logic [QUOT_W-1:0]  qx, qy;
  } div_t;

endpackage

### rtl/homography_inverse_map_top.sv
// Stages from an accepted input beat to its result beat: 2 multiply/sum stages,
// 1 sign and range stage, 10 divide stages, 1 output stage.
// Throughput: one beat per cycle; the whole pipeline advances when the output
// register is empty or taken, so a stall holds every stage in place.
// Reset (rst, synchronous): clears all valid bits and loads the identity
// transform with a 1024 x 1024 source image.
module homography_inverse_map_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [hinv_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [hinv_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // dest_col [9:0], dest_row [19:10], zero [23:20]
  input  logic [hinv_pkg::IN_W-1:0]         s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // src_col [9:0], src_row [19:10], inside_res [20], zero [23:21]
  output logic [hinv_pkg::OUT_W-1:0]        m_tdata
);
  import hinv_pkg::*;

  logic [CFG_W-1:0]   r1ab, r1c2a, r2bc, r3ab;
  logic [COEF_W-1:0]  r3c;
  logic [BOUND_W-1:0] src_w, src_h, wb, hb;

  always_ff @(posedge clk) begin
    if (rst) begin
      r1ab  <= 64'h4000_0000_0000_0000;
      r1c2a <= '0;
      r2bc  <= 64'h4000_0000_0000_0000;
      r3ab  <= '0;
      r3c   <= 32'h4000_0000;
      src_w <= BOUND_W'(1024);
      src_h <= BOUND_W'(1024);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_ROW1_AB:     r1ab  <= cfg_data;
        REG_ROW1C_ROW2A: r1c2a <= cfg_data;
        REG_ROW2_BC:     r2bc  <= cfg_data;
        REG_ROW3_AB:     r3ab  <= cfg_data;
        REG_ROW3_C:      r3c   <= cfg_data[COEF_W-1:0];
        REG_SRC_WIDTH:   src_w <= cfg_data[BOUND_W-1:0];
        REG_SRC_HEIGHT:  src_h <= cfg_data[BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  coef_t coef;
  assign coef.h11 = r1ab[63:32];
  assign coef.h12 = r1ab[31:0];
  assign coef.h13 = r1c2a[63:32];
  assign coef.h21 = r1c2a[31:0];
  assign coef.h22 = r2bc[63:32];
  assign coef.h23 = r2bc[31:0];
  assign coef.h31 = r3ab[63:32];
  assign coef.h32 = r3ab[31:0];
  assign coef.h33 = r3c;

  assign wb = (src_w > MAX_COLS) ? MAX_COLS : src_w;
  assign hb = (src_h > MAX_ROWS) ? MAX_ROWS : src_h;

  logic en;
  assign en       = m_tready || !m_tvalid;
  assign s_tready = en;

  logic  mac_v;
  proj_t proj;

  hinv_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vin  (s_tvalid),
    .c    (s_tdata[COORD_W-1:0]),
    .r    (s_tdata[2*COORD_W-1:COORD_W]),
    .coef (coef),
    .vout (mac_v),
    .proj (proj)
  );

  // sign and range stage
  logic [ACC_W-1:0]        nx, ny, dm;
  logic [ACC_W+QUOT_W-1:0] lim;
  logic                    sx_ok, sy_ok;
  div_t                    dv [0:QUOT_W];
  logic                    dvv [0:QUOT_W];

  assign nx    = proj.x[ACC_W-1] ? ACC_W'(-proj.x) : ACC_W'(proj.x);
  assign ny    = proj.y[ACC_W-1] ? ACC_W'(-proj.y) : ACC_W'(proj.y);
  assign dm    = proj.w[ACC_W-1] ? ACC_W'(-proj.w) : ACC_W'(proj.w);
  assign lim   = {dm, {QUOT_W{1'b0}}};
  assign sx_ok = (proj.x == '0) || (proj.x[ACC_W-1] == proj.w[ACC_W-1]);
  assign sy_ok = (proj.y == '0) || (proj.y[ACC_W-1] == proj.w[ACC_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      dvv[0] <= 1'b0;
    end else if (en) begin
      dvv[0] <= mac_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // quotient must fit the divide stages, else the point is out anyway
      dv[0].okx <= sx_ok && ({{QUOT_W{1'b0}}, nx} < lim);
      dv[0].oky <= sy_ok && ({{QUOT_W{1'b0}}, ny} < lim);
      dv[0].rx  <= nx;
      dv[0].ry  <= ny;
      dv[0].d   <= dm;
      dv[0].qx  <= '0;
      dv[0].qy  <= '0;
    end
  end

  for (genvar i = 0; i < QUOT_W; i++) begin : g_div
    hinv_div_step #(.SHIFT(QUOT_W - 1 - i)) u_step (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .vin  (dvv[i]),
      .din  (dv[i]),
      .vout (dvv[i+1]),
      .dout (dv[i+1])
    );
  end

  logic in_img;
  assign in_img = dv[QUOT_W].okx && dv[QUOT_W].oky
               && ({1'b0, dv[QUOT_W].qx} < wb) && ({1'b0, dv[QUOT_W].qy} < hb);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dvv[QUOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {3'b000, in_img,
                  in_img ? dv[QUOT_W].qy : {QUOT_W{1'b0}},
                  in_img ? dv[QUOT_W].qx : {QUOT_W{1'b0}}};
    end
  end

  a_out_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[20] |-> m_tdata[19:0] == '0)
    else $error("outside result carries nonzero coordinates");

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[20] |-> {1'b0, m_tdata[9:0]} < wb)
    else $error("inside column beyond source width");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[20] |-> {1'b0, m_tdata[19:10]} < hb)
    else $error("inside row beyond source height");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid && !dvv[QUOT_W])
    else $error("pipeline not empty after reset");

endmodule

### rtl/hinv_mac.sv
module hinv_mac (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             vin,
  input  logic [hinv_pkg::COORD_W-1:0]     c,
  input  logic [hinv_pkg::COORD_W-1:0]     r,
  input  hinv_pkg::coef_t                  coef,
  output logic                             vout,
  output hinv_pkg::proj_t                  proj
);
  import hinv_pkg::*;

  logic signed [PROD_W-1:0] p11, p12, p21, p22, p31, p32;
  logic signed [COEF_W-1:0] k13, k23, k33;
  logic                     v1;
  logic signed [COORD_W:0]  cs, rs;
  logic signed [ACC_W-1:0]  wsum;

  assign cs = $signed({1'b0, c});
  assign rs = $signed({1'b0, r});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      vout <= 1'b0;
    end else if (en) begin
      v1   <= vin;
      vout <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p11 <= PROD_W'(coef.h11 * cs);
      p12 <= PROD_W'(coef.h12 * rs);
      p21 <= PROD_W'(coef.h21 * cs);
      p22 <= PROD_W'(coef.h22 * rs);
      p31 <= PROD_W'(coef.h31 * cs);
      p32 <= PROD_W'(coef.h32 * rs);
      k13 <= coef.h13;
      k23 <= coef.h23;
      k33 <= coef.h33;
    end
  end

  assign wsum = ACC_W'(p31) + ACC_W'(p32) + ACC_W'(k33);

  always_ff @(posedge clk) begin
    if (en) begin
      proj.x <= ACC_W'(p11) + ACC_W'(p12) + ACC_W'(k13);
      proj.y <= ACC_W'(p21) + ACC_W'(p22) + ACC_W'(k23);
      // zero w stands for exactly one
      proj.w <= (wsum == '0) ? (ACC_W'(1) <<< FRAC_BITS) : wsum;
    end
  end

endmodule

### rtl/hinv_div_step.sv
module hinv_div_step #(
  parameter int SHIFT = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vin,
  input  hinv_pkg::div_t din,
  output logic          vout,
  output hinv_pkg::div_t dout
);
  import hinv_pkg::*;

  localparam int EXT_W = ACC_W + QUOT_W;

  logic [EXT_W-1:0] dsh;
  div_t             nxt;

  assign dsh = {{QUOT_W{1'b0}}, din.d} << SHIFT;

  always_comb begin
    nxt = din;
    if ({{QUOT_W{1'b0}}, din.rx} >= dsh) begin
      nxt.rx        = din.rx - dsh[ACC_W-1:0];
      nxt.qx[SHIFT] = 1'b1;
    end
    if ({{QUOT_W{1'b0}}, din.ry} >= dsh) begin
      nxt.ry        = din.ry - dsh[ACC_W-1:0];
      nxt.qy[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule
